[design/ebh_pkg.sv]
// ebh_pkg: shared types, constants and helpers for the edge binned histogram.
// Used by ebh_cell, ebh_dump, edge_binned_histogram and ebh_checker.
package ebh_pkg;

   // sizing
   localparam int MAX_BINS      = 8;
   localparam int COUNT_WIDTH   = 32;
   localparam int SAMPLE_WIDTH  = 32;
   localparam int EDGE_WIDTH    = 32;
   localparam int EDGE_REGS     = 7;
   localparam int BIN_IDX_WIDTH = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CMP_WIDTH     = (SAMPLE_WIDTH > EDGE_WIDTH) ? SAMPLE_WIDTH : EDGE_WIDTH;
   localparam int MAX_EDGE      = (MAX_BINS - 1 < EDGE_REGS) ? MAX_BINS - 1 : EDGE_REGS;

   // result field widths
   localparam int OUT_IDX_WIDTH   = 3;
   localparam int OUT_COUNT_WIDTH = 32;

   // register file
   localparam int NUM_EDGES_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int REG_IDX_WIDTH   = CSR_ADDR_WIDTH - 2;

   localparam logic [REG_IDX_WIDTH-1:0] REG_NUM_EDGES = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_EDGE_0    = 3'd1;

   // command codes
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_DUMP  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [EDGE_WIDTH-1:0]   edge_type;
   typedef logic signed [CMP_WIDTH-1:0]    cmp_type;
   typedef logic [BIN_IDX_WIDTH-1:0]       bin_idx_type;
   typedef logic [NUM_EDGES_WIDTH-1:0]     num_edges_type;
   typedef count_type [MAX_BINS-1:0]       snap_type;

   typedef struct packed {
      logic [1:0]        command;
      sample_type        sample_value;
   } req_word_type;

   typedef struct packed {
      logic [OUT_IDX_WIDTH-1:0]   bin_index;
      logic [OUT_COUNT_WIDTH-1:0] bin_count;
      logic                       last;
   } rsp_word_type;

   // one word as it travels along the row of cells
   typedef struct packed {
      logic       valid;
      logic [1:0] command;
      sample_type sample;
      logic       found;
      snap_type   snap;
   } item_type;

   // control from the result stage back to the chain
   typedef struct packed {
      logic hold;
      logic load;
   } dump_ctrl_type;

   // active edge count, limited by the bin count and the edge registers
   function automatic bin_idx_type active_edges(input num_edges_type num);
      num_edges_type n;
      n = num;
      if (int'(n) > MAX_EDGE) n = num_edges_type'(MAX_EDGE);
      return bin_idx_type'(n);
   endfunction

endpackage

[design/ebh_cell.sv]
// ebh_cell: one bin of the histogram chain; holds one counter and one edge compare.
// Depends on ebh_pkg.
module ebh_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               edge_on,
   input  ebh_pkg::edge_type  bin_edge,
   input  ebh_pkg::item_type  prev_item,
   output ebh_pkg::item_type  next_item
);

   ebh_pkg::count_type count_ff, count_in;
   ebh_pkg::item_type  item_ff, item_in;
   ebh_pkg::cmp_type   samp_x, edge_x;
   logic               match, take;

   assign samp_x = ebh_pkg::cmp_type'($signed(prev_item.sample));
   assign edge_x = ebh_pkg::cmp_type'($signed(bin_edge));

   always_comb begin
      // a disabled edge takes whatever has not been placed yet
      match = !edge_on || (samp_x < edge_x);
      take  = prev_item.valid && (prev_item.command == ebh_pkg::CMD_ADD) &&
              !prev_item.found && match;

      count_in = count_ff;
      if (advance && prev_item.valid) begin
         if (take && (count_ff != '1)) count_in = count_ff + 1'b1;
         if (prev_item.command == ebh_pkg::CMD_CLEAR) count_in = '0;
      end

      item_in       = prev_item;
      item_in.found = prev_item.found | take;
      // shift the snapshot down, append this bin at the top
      item_in.snap  = {count_ff, prev_item.snap[ebh_pkg::MAX_BINS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         item_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (advance) item_ff <= item_in;
      end
   end

   assign next_item = item_ff;

endmodule

[design/ebh_dump.sv]
// ebh_dump: result stage; unrolls a dump snapshot into one word per active bin.
// Depends on ebh_pkg.
module ebh_dump (
   input  logic                  clock,
   input  logic                  reset,
   input  ebh_pkg::item_type     tail_item,
   input  ebh_pkg::bin_idx_type  n_act,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output ebh_pkg::rsp_word_type rsp_word,
   output ebh_pkg::dump_ctrl_type ctrl
);

   logic                 active_ff, active_in;
   ebh_pkg::bin_idx_type idx_ff, idx_in;
   ebh_pkg::snap_type    snap_ff, snap_in;
   logic                 last_word, free, tail_dump;

   always_comb begin
      last_word = (idx_ff == n_act);
      free      = !active_ff || (last_word && !rsp_stall);
      tail_dump = tail_item.valid && (tail_item.command == ebh_pkg::CMD_DUMP);
      ctrl.load = tail_dump && free;
      ctrl.hold = tail_dump && !free;

      active_in = active_ff;
      idx_in    = idx_ff;
      snap_in   = snap_ff;
      if (ctrl.load) begin
         active_in = 1'b1;
         idx_in    = '0;
         snap_in   = tail_item.snap;
      end else if (active_ff && !rsp_stall) begin
         if (last_word) begin
            active_in = 1'b0;
         end else begin
            idx_in  = ebh_pkg::bin_idx_type'(idx_ff + 1'b1);
            snap_in = {ebh_pkg::count_type'(0), snap_ff[ebh_pkg::MAX_BINS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      snap_ff <= snap_in;
   end

   assign rsp_valid          = active_ff;
   assign rsp_word.bin_index = ebh_pkg::OUT_IDX_WIDTH'(idx_ff);
   assign rsp_word.bin_count = ebh_pkg::OUT_COUNT_WIDTH'(snap_ff[0]);
   assign rsp_word.last      = last_word;

endmodule

[design/edge_binned_histogram.sv]
// edge_binned_histogram: histogram with programmable bin edges, built as a row of bin cells.
// Depends on ebh_pkg, ebh_cell and ebh_dump.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_word: command, sample_value
//   rsp_     out        rsp_valid / rsp_stall  rsp_word: bin_index, bin_count, last
//   csr_     in/out     APB, pready always 1   num_edges at 0x00, edge_0..edge_6 at 0x04..0x1C
//
// One input word is taken per cycle while req_stall is low. Each word walks the row of
// MAX_BINS cells, one cell per cycle while the row is not held, so the first dump word
// shows once its dump has passed every cell register and been loaded into the result stage.
// A dump drains num_edges + 1 words, one per cycle unless rsp_stall is high; while it
// drains, a second dump that reaches the end of the row holds the whole row and raises
// req_stall. Synchronous reset clears counters, registers and all valid flags.
// rsp_stall holds the current result word unchanged.
module edge_binned_histogram (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ebh_pkg::req_word_type                req_word,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ebh_pkg::rsp_word_type                rsp_word,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ebh_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [ebh_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [ebh_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   // ---------------- registers ----------------
   ebh_pkg::num_edges_type num_edges_ff;
   ebh_pkg::edge_type      edge_ff [ebh_pkg::EDGE_REGS];
   logic [ebh_pkg::REG_IDX_WIDTH-1:0] reg_idx;
   logic                   csr_write;
   ebh_pkg::bin_idx_type   n_act;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ebh_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_edges_ff <= '0;
         for (int i = 0; i < ebh_pkg::EDGE_REGS; i++) edge_ff[i] <= '0;
      end else if (csr_write) begin
         if (reg_idx == ebh_pkg::REG_NUM_EDGES) begin
            num_edges_ff <= csr_pwdata[ebh_pkg::NUM_EDGES_WIDTH-1:0];
         end else begin
            edge_ff[reg_idx - ebh_pkg::REG_EDGE_0] <= csr_pwdata[ebh_pkg::EDGE_WIDTH-1:0];
         end
      end
   end

   // read back
   always_comb begin
      if (reg_idx == ebh_pkg::REG_NUM_EDGES) begin
         csr_prdata = ebh_pkg::CSR_DATA_WIDTH'(num_edges_ff);
      end else begin
         csr_prdata = ebh_pkg::CSR_DATA_WIDTH'(edge_ff[reg_idx - ebh_pkg::REG_EDGE_0]);
      end
   end

   assign n_act = ebh_pkg::active_edges(num_edges_ff);

   // ---------------- row of bin cells ----------------
   ebh_pkg::item_type      chain [ebh_pkg::MAX_BINS+1];
   ebh_pkg::edge_type      cell_edge [ebh_pkg::MAX_BINS];
   logic                   edge_on [ebh_pkg::MAX_BINS];
   ebh_pkg::dump_ctrl_type dump_ctrl;
   logic                   advance;

   // the whole row moves together; only a blocked dump at the end holds it
   assign advance   = !dump_ctrl.hold;
   assign req_stall = dump_ctrl.hold;

   // build the entry word: not yet placed, empty snapshot
   always_comb begin
      chain[0].valid   = req_valid;
      chain[0].command = req_word.command;
      chain[0].sample  = req_word.sample_value;
      chain[0].found   = 1'b0;
      chain[0].snap    = '0;
   end

   for (genvar g = 0; g < ebh_pkg::MAX_BINS; g++) begin : g_cell
      if (g < ebh_pkg::EDGE_REGS) begin : g_edge
         assign cell_edge[g] = edge_ff[g];
      end else begin : g_no_edge
         assign cell_edge[g] = '0;
      end
      // cells past the active edges catch everything still unplaced
      assign edge_on[g] = (ebh_pkg::bin_idx_type'(g) < n_act);

      ebh_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .edge_on   (edge_on[g]),
         .bin_edge  (cell_edge[g]),
         .prev_item (chain[g]),
         .next_item (chain[g+1])
      );
   end

   // ---------------- result stage ----------------
   ebh_dump u_dump (
      .clock     (clock),
      .reset     (reset),
      .tail_item (chain[ebh_pkg::MAX_BINS]),
      .n_act     (n_act),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .ctrl      (dump_ctrl)
   );

endmodule

[design/ebh_checker.sv]
// ebh_checker: port-level checks for edge_binned_histogram, bound to the top level.
// Depends on ebh_pkg and edge_binned_histogram.
module ebh_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ebh_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed under stall");

   // reset empties the result stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a dump continues with the next bin in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_word.last |=>
         rsp_valid && (rsp_word.bin_index ==
            ebh_pkg::OUT_IDX_WIDTH'($past(rsp_word.bin_index) + 1'b1)))
      else $error("dump words out of order");

   // after the last word, any new dump starts at bin zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word.last |=> !rsp_valid || (rsp_word.bin_index == '0))
      else $error("dump did not start at bin zero");

   // the input only stalls behind a draining dump
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind edge_binned_histogram ebh_checker u_ebh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[sim/tb.sv]
// tb: self-checking testbench for edge_binned_histogram, with a bin predictor and dump checker.
// Depends on ebh_pkg and the edge_binned_histogram RTL; drives the req_, rsp_ and csr_ ports.
`timescale 1ns / 100ps

module tb;
   import ebh_pkg::*;

   // command code with no meaning; the block must ignore it
   localparam logic [1:0] CMD_NONE = 2'd3;

   // cycles to let adds and clears leave the row of cells before a register write
   localparam int SETTLE = 2 * MAX_BINS + 8;
   // cycles with no handshake at all before the run is called hung
   localparam int HANG_LIMIT = 4000;

   localparam edge_type Q_ONE    = edge_type'(32'h0001_0000);
   localparam edge_type EDGE_MIN = edge_type'(32'h8000_0000);
   localparam edge_type EDGE_MAX = edge_type'(32'h7FFF_FFFF);

   typedef edge_type edge_set_type [EDGE_REGS];

   // ------------------------------------------------------------------
   // Bin predictor and store of pending dump words
   // ------------------------------------------------------------------
   class bin_scoreboard;
      num_edges_type edge_count;
      edge_type      edges [EDGE_REGS];
      count_type     counts [MAX_BINS];
      rsp_word_type  dump_words [$];
      int            errors;
      int            checked;

      function new();
         edge_count = '0;
         foreach (edges[k]) edges[k] = '0;
         foreach (counts[k]) counts[k] = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function int pending();
         return dump_words.size();
      endfunction

      // mirror a register write
      function void set_reg(input int idx, input logic [CSR_DATA_WIDTH-1:0] data);
         if (idx == int'(REG_NUM_EDGES)) begin
            edge_count = data[NUM_EDGES_WIDTH-1:0];
         end else if (idx >= int'(REG_EDGE_0) && idx < int'(REG_EDGE_0) + EDGE_REGS) begin
            edges[idx - int'(REG_EDGE_0)] = edge_type'(data);
         end
      endfunction

      // advance the predicted state by one accepted input word
      function void note(input req_word_type w);
         int unsigned  live;
         int unsigned  b;
         sample_type   s;
         rsp_word_type r;
         live = (int'(edge_count) > MAX_EDGE) ? MAX_EDGE : int'(edge_count);
         s = w.sample_value;
         case (w.command)
            CMD_ADD: begin
               // first edge above the sample wins, even when edges are unsorted
               b = 0;
               while (b < live && s >= edges[b]) b++;
               if (counts[b] != '1) counts[b]++;
            end
            CMD_DUMP: begin
               for (b = 0; b <= live; b++) begin
                  r.bin_index = OUT_IDX_WIDTH'(b);
                  r.bin_count = OUT_COUNT_WIDTH'(counts[b]);
                  r.last      = (b == live);
                  dump_words.push_back(r);
               end
            end
            CMD_CLEAR: begin
               foreach (counts[k]) counts[k] = '0;
            end
            default: ;
         endcase
      endfunction

      task report(input string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      // compare one accepted result word with the oldest pending one
      task check(input rsp_word_type got);
         rsp_word_type want;
         if (dump_words.size() == 0) begin
            report($sformatf("unexpected word: bin %0d count %0d last %0b",
                             got.bin_index, got.bin_count, got.last));
            return;
         end
         want = dump_words.pop_front();
         checked++;
         if (got.bin_index !== want.bin_index)
            report($sformatf("bin_index: got %0d, want %0d", got.bin_index, want.bin_index));
         if (got.bin_count !== want.bin_count)
            report($sformatf("bin_count of bin %0d: got %0d, want %0d",
                             want.bin_index, got.bin_count, want.bin_count));
         if (got.last !== want.last)
            report($sformatf("last of bin %0d: got %0b, want %0b",
                             want.bin_index, got.last, want.last));
      endtask
   endclass

   // ------------------------------------------------------------------
   // Signals; every input of the block starts at a known value
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;

   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   bin_scoreboard hist = new();

   bit idle_on  = 1'b1;   // sender gaps allowed
   bit stall_on = 1'b1;   // receiver stalls allowed
   int words_sent    = 0;
   int settings_used = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;

   edge_binned_histogram uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Receiver: at random, start a stall burst of random length while stalls are allowed.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every result word taken at this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) hist.check(rsp_word);
   end

   // Watchdog: count cycles with no handshake on any port; end the run when stuck.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Send one input word; hold it until taken, then feed it to the predictor.
   task automatic send_word(input logic [1:0] cmd, input sample_type value);
      req_word_type w;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      w.command      = cmd;
      w.sample_value = value;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      hist.note(w);
      if (cmd != CMD_NONE) words_sent++;
   endtask

   // Drop valid and wait until every pending dump word has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (hist.pending() != 0);
   endtask

   // Drain, then let adds and clears still in the row of cells finish.
   task automatic wait_idle();
      drain_results();
      repeat (SETTLE) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input int idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(idx * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      hist.set_reg(idx, data);
   endtask

   // Write every register with the block idle.
   task automatic program_regs(input num_edges_type n, input edge_set_type e);
      logic [CSR_DATA_WIDTH-1:0] w;
      wait_idle();
      // junk in the upper bits of num_edges must be dropped by the block
      w = $urandom;
      w[NUM_EDGES_WIDTH-1:0] = n;
      csr_write(int'(REG_NUM_EDGES), w);
      for (int k = 0; k < EDGE_REGS; k++) csr_write(int'(REG_EDGE_0) + k, e[k]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_used++;
   endtask

   // Edge values: full range, near zero in Q16.16, or a signed extreme.
   function automatic edge_type pick_edge();
      case ($urandom_range(0, 3))
         0:       return edge_type'($urandom);
         3:       return ($urandom_range(0, 1) != 0) ? EDGE_MAX : EDGE_MIN;
         default: return edge_type'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      endcase
   endfunction

   task automatic program_random(input num_edges_type n, input bit sorted, input bit extremes);
      edge_type     q [$];
      edge_set_type e;
      for (int k = 0; k < EDGE_REGS; k++) q.push_back(pick_edge());
      if (extremes) begin
         q[0] = EDGE_MIN;
         q[1] = EDGE_MAX;
      end
      if (sorted) q.sort();
      foreach (e[k]) e[k] = q[k];
      program_regs(n, e);
   endtask

   // Samples: full range, near zero, or on and around an edge.
   function automatic sample_type pick_sample();
      int k;
      case ($urandom_range(0, 3))
         0: return sample_type'($urandom);
         1: return sample_type'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
         default: begin
            k = $urandom_range(0, EDGE_REGS - 1);
            return sample_type'(int'(hist.edges[k]) + int'($urandom_range(0, 2)) - 1);
         end
      endcase
   endfunction

   // Mostly adds with random content; dumps, clears and the dead code mixed in.
   task automatic run_random(input int count, input bit pause_mid);
      int         done;
      int         r;
      logic [1:0] cmd;
      done = 0;
      while (done < count) begin
         r = $urandom_range(0, 99);
         if (r < 78)      cmd = CMD_ADD;
         else if (r < 90) cmd = CMD_DUMP;
         else if (r < 95) cmd = CMD_CLEAR;
         else             cmd = CMD_NONE;
         send_word(cmd, pick_sample());
         if (cmd != CMD_NONE) done++;
         // hold off the sender once until the dump backlog is empty
         if (pause_mid && done >= count / 2) begin
            drain_results();
            pause_mid = 1'b0;
         end
      end
      // read the counts out at the end of every setting
      send_word(CMD_DUMP, sample_type'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dump in the reset state: one bin, empty
      send_word(CMD_DUMP, '0);

      // edges at -1.0, 0.0 and 1.0; the rest are unused
      program_regs(3'd3, '{-Q_ONE, edge_type'(0), Q_ONE, pick_edge(), pick_edge(),
                           pick_edge(), pick_edge()});
      send_word(CMD_ADD, sample_type'(32'h8000_0000));   // most negative: bin 0
      send_word(CMD_ADD, sample_type'(32'h7FFF_FFFF));   // most positive: top bin
      send_word(CMD_ADD, sample_type'(32'hFFFF_0000));   // equal to an edge: next bin
      send_word(CMD_ADD, sample_type'(32'hFFFE_FFFF));   // just under an edge
      send_word(CMD_ADD, sample_type'(0));
      send_word(CMD_ADD, sample_type'(32'h0000_FFFF));
      send_word(CMD_ADD, sample_type'(32'h0001_0000));
      send_word(CMD_NONE, sample_type'(0));              // ignored
      send_word(CMD_DUMP, sample_type'(32'hFFFF_FFFF));
      send_word(CMD_CLEAR, sample_type'(32'h5555_5555));
      send_word(CMD_DUMP, '0);
      send_word(CMD_ADD, sample_type'(32'h5555_5555));
      send_word(CMD_ADD, sample_type'(32'hAAAA_AAAA));
      send_word(CMD_DUMP, '0);

      // every edge register in use, out of order, with both signed extremes among them
      program_regs(3'd7, '{edge_type'(32'h000A_0000), edge_type'(32'hFFFB_0000),
                           edge_type'(32'h0014_0000), EDGE_MIN, EDGE_MAX,
                           edge_type'(0), edge_type'(32'hFFFF_FFFF)});
      send_word(CMD_ADD, sample_type'(32'hFFFA_0000));   // -6.0 below the first edge
      send_word(CMD_ADD, sample_type'(32'h000F_0000));   // 15.0 stops at the edge at 20.0
      send_word(CMD_ADD, sample_type'(32'h7FFF_FFFF));   // equal to the largest edge, below none: last bin
      send_word(CMD_ADD, sample_type'(32'h8000_0000));
      send_word(CMD_DUMP, '0);
      send_word(CMD_DUMP, '0);                           // back to back: row must hold
      send_word(CMD_CLEAR, '0);
      send_word(CMD_DUMP, '0);

      // random part over several settings, extremes of num_edges among them
      program_random(3'd0, 1'b1, 1'b0);
      run_random(25, 1'b0);
      program_random(3'd7, 1'b1, 1'b0);
      run_random(30, 1'b1);
      program_random(num_edges_type'($urandom_range(1, 6)), 1'b1, 1'b0);
      run_random(30, 1'b0);
      program_random(num_edges_type'($urandom_range(1, 7)), 1'b0, 1'b0);
      run_random(30, 1'b0);
      program_random(3'd7, 1'b1, 1'b1);
      run_random(30, 1'b0);

      // last stretch at full rate on both sides
      idle_on  = 1'b0;
      stall_on = 1'b0;
      program_random(num_edges_type'($urandom_range(0, 7)), 1'b0, 1'b1);
      run_random(25, 1'b0);

      // wait for the last dump words, then for the row to empty
      wait_idle();

      $display("Covered %0d input words over %0d bin settings (sorted, unsorted, extremes).",
               words_sent, settings_used);
      $display("Compared %0d result words, %0d mismatches.", hist.checked, hist.errors);
      if (hist.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
